FILE: design/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared sizes, types and codes for the pixel palette indexer.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

    localparam int CH_W     = 7;
    localparam int COLOR_W  = 24;
    localparam int CODE_W   = 2 * CH_W;
    localparam int PIXEL_W  = 14;

    localparam int INDEX_OUT_W = 8;
    localparam int COUNT_OUT_W = 9;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CODE_W-1:0]  code;
    } entry_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_LIMIT = 2'd2
    } status_t;

endpackage

FILE: design/pixel_palette_indexer.sv
// ----------------------------------------------------------------------------
// pixel_palette_indexer
// Palette builder: looks up each RGB pixel within the pixel limit, appends new colors with codes while room remains.
// ----------------------------------------------------------------------------
// Raise start for one cycle while busy is low to hand in a pixel beat. The
// block scans its palette memory one entry per cycle through a single read
// port with registered read data, until the color is found (hit) or every
// entry held has been read (miss); busy stays high for the scan, so a new
// pixel is taken only once the last one is answered. A pixel beyond the
// max_pixels limit is answered at once and never raises busy. Each result
// beat appears for exactly one cycle with done high; there is no
// back-pressure, so capture it then. busy falls in the cycle done rises, so
// the next pixel may be started while the result is on the ports. Write
// max_pixels (cfg_we/cfg_data) only while the block is idle. first_pixel
// clears the palette, the pixel count and the code counter before that
// pixel is used.
// ----------------------------------------------------------------------------
module pixel_palette_indexer
    import ppi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    input  logic                   first_pixel,
    input  logic                   cfg_we,
    input  logic [PIXEL_W-1:0]     cfg_data,
    output logic                   done,
    output logic [CH_W-1:0]        code_first,
    output logic [CH_W-1:0]        code_second,
    output logic [INDEX_OUT_W-1:0] color_index,
    output logic                   is_new,
    output logic [COUNT_OUT_W-1:0] color_count,
    output logic [1:0]             status
);

    localparam logic [CH_W-1:0]    CH_FIRST  = CH_W'(33);
    localparam logic [CH_W-1:0]    CH_QUOTE  = CH_W'(34);
    localparam logic [CH_W-1:0]    CH_LAST   = CH_W'(127);
    localparam logic [PIXEL_W-1:0] PIXEL_SAT = '1;
    localparam logic [PIXEL_W-1:0] MAX_RST   = PIXEL_W'(8000);
    localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    // Step one code character: wrap past 127 and hop over the double quote.
    function automatic logic [CH_W-1:0] step_char(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] nxt;
        nxt = (ch >= CH_LAST) ? CH_FIRST : ch + CH_W'(1);
        if (nxt == CH_QUOTE)
        begin
            nxt = nxt + CH_W'(1);
        end
        return nxt;
    endfunction

    state_t              state_reg, state_next;
    logic [PIXEL_W-1:0]  max_pixels_reg;
    logic [PIXEL_W-1:0]  seen_reg, seen_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CH_W-1:0]     nc_first_reg, nc_first_next;
    logic [CH_W-1:0]     nc_second_reg, nc_second_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;

    logic                   done_reg, done_next;
    logic [CH_W-1:0]        code_first_reg, code_first_next;
    logic [CH_W-1:0]        code_second_reg, code_second_next;
    logic [INDEX_OUT_W-1:0] index_reg, index_next;
    logic                   is_new_reg, is_new_next;
    logic [COUNT_OUT_W-1:0] count_reg, count_next;
    status_t                status_reg, status_next;

    logic               accept;
    logic [PIXEL_W-1:0] seen_base;
    logic               issue;
    logic               hit;
    logic               wr_en;
    entry_t             wr_data;
    entry_t             rd_data;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Read the next entry while any remain; compare the entry read last cycle.
    assign issue = (state_reg == S_SCAN) && (scan_idx_reg < used_reg);
    assign hit   = (state_reg == S_SCAN) && cmp_valid_reg && (rd_data.color == color_reg);

    assign wr_data.color = color_reg;
    assign wr_data.code  = {nc_first_reg, nc_second_reg};

    ppi_palette_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (used_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        seen_next        = seen_reg;
        used_next        = used_reg;
        nc_first_next    = nc_first_reg;
        nc_second_next   = nc_second_reg;
        color_next       = color_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = scan_idx_reg[IDX_W-1:0];
        done_next        = 1'b0;
        code_first_next  = code_first_reg;
        code_second_next = code_second_reg;
        index_next       = index_reg;
        is_new_next      = is_new_reg;
        count_next       = count_reg;
        status_next      = status_reg;
        wr_en            = 1'b0;
        seen_base        = first_pixel ? '0 : seen_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    color_next = {red, green, blue};
                    if (first_pixel)
                    begin
                        used_next      = '0;
                        nc_first_next  = CH_FIRST;
                        nc_second_next = CH_FIRST;
                    end
                    seen_next = (seen_base == PIXEL_SAT) ? seen_base
                                                         : seen_base + PIXEL_W'(1);
                    if (seen_next > max_pixels_reg)
                    begin
                        // Over the limit: answer at once, no search, no insert.
                        done_next        = 1'b1;
                        code_first_next  = '0;
                        code_second_next = '0;
                        index_next       = '0;
                        is_new_next      = 1'b0;
                        count_next       = COUNT_OUT_W'(used_next);
                        status_next      = ST_LIMIT;
                    end
                    else
                    begin
                        state_next    = S_SCAN;
                        scan_idx_next = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                end
                if (hit)
                begin
                    state_next       = S_IDLE;
                    done_next        = 1'b1;
                    code_first_next  = rd_data.code[CODE_W-1:CH_W];
                    code_second_next = rd_data.code[CH_W-1:0];
                    index_next       = INDEX_OUT_W'(cmp_idx_reg);
                    is_new_next      = 1'b0;
                    count_next       = COUNT_OUT_W'(used_reg);
                    status_next      = ST_OK;
                end
                else if (!issue && !cmp_valid_reg)
                begin
                    // Scan exhausted without a match.
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (used_reg >= DEPTH_CNT)
                    begin
                        code_first_next  = '0;
                        code_second_next = '0;
                        index_next       = '0;
                        is_new_next      = 1'b0;
                        count_next       = COUNT_OUT_W'(used_reg);
                        status_next      = ST_FULL;
                    end
                    else
                    begin
                        wr_en            = 1'b1;
                        used_next        = used_reg + CNT_W'(1);
                        code_first_next  = nc_first_reg;
                        code_second_next = nc_second_reg;
                        index_next       = INDEX_OUT_W'(used_reg);
                        is_new_next      = 1'b1;
                        count_next       = COUNT_OUT_W'(used_next);
                        status_next      = ST_OK;
                        if (nc_second_reg == CH_LAST)
                        begin
                            nc_second_next = CH_FIRST;
                            nc_first_next  = step_char(nc_first_reg);
                        end
                        else
                        begin
                            nc_second_next = step_char(nc_second_reg);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_pixels_reg <= MAX_RST;
            seen_reg       <= '0;
            used_reg       <= '0;
            nc_first_reg   <= CH_FIRST;
            nc_second_reg  <= CH_FIRST;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            used_reg      <= used_next;
            nc_first_reg  <= nc_first_next;
            nc_second_reg <= nc_second_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                max_pixels_reg <= cfg_data;
            end
        end
    end

    // Payload registers: hold between beats.
    always_ff @(posedge clk)
    begin
        color_reg       <= color_next;
        cmp_idx_reg     <= cmp_idx_next;
        code_first_reg  <= code_first_next;
        code_second_reg <= code_second_next;
        index_reg       <= index_next;
        is_new_reg      <= is_new_next;
        count_reg       <= count_next;
        status_reg      <= status_next;
    end

    assign done        = done_reg;
    assign code_first  = code_first_reg;
    assign code_second = code_second_reg;
    assign color_index = index_reg;
    assign is_new      = is_new_reg;
    assign color_count = count_reg;
    assign status      = status_reg;

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= used_reg))
        else $error("scan index ran past the entry count");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_SCAN) && (used_reg < DEPTH_CNT) && !hit))
        else $error("palette write without room or on a hit");

    a_new_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && is_new_reg) |-> (status_reg == ST_OK))
        else $error("new entry reported with an error status");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ST_OK)) |-> (!is_new_reg && (index_reg == '0)))
        else $error("error beat carries an index or new flag");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result beat while still scanning");

endmodule

FILE: design/ppi_palette_mem.sv
// ----------------------------------------------------------------------------
// ppi_palette_mem
// Palette storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ppi_palette_mem
    import ppi_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [PALETTE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
